// ----- rtl/ssw_pkg.sv -----
// Shared types, constants and arithmetic helpers for the symmetric septic weight block.
package ssw_pkg;

  localparam int CoordW    = 17;
  localparam int PowW      = 23;
  localparam int MonoShift = 16;
  localparam int MonoW     = 26;
  localparam int CoefW     = 16;
  localparam int ProdW     = 43;
  localparam int AccW      = 48;
  localparam int ResW      = 32;
  localparam int FracDrop  = 12;
  localparam int NumCoef   = 13;
  localparam int NumGroups = 4;
  localparam int NumStages = 10;
  localparam int PowStages = 4;
  localparam int MonStages = 2;
  localparam int AccStages = 4;
  localparam int CfgAddrW  = 5;
  localparam int CfgDataW  = 64;
  localparam int CfgRegW   = 16;

  localparam logic [PowW-1:0] OneQ16 = PowW'(65536);

  typedef enum logic [1:0] {
    RegCoef0 = 2'd0,
    RegCoef1 = 2'd1,
    RegCoef2 = 2'd2,
    RegCoef3 = 2'd3
  } reg_idx_e;

  typedef logic [PowW-1:0]              pow_t;
  typedef pow_t [7:0]                   pows_t;
  typedef pow_t [7:0][7:0]              cross_t;
  typedef logic [MonoW-1:0]             msum_t;
  typedef msum_t [NumCoef-1:0]          msums_t;
  typedef logic [NumCoef-1:0][CoefW-1:0] coefs_t;
  typedef logic signed [ProdW-1:0]      prod_t;
  typedef prod_t [NumCoef-1:0]          prods_t;
  typedef logic signed [AccW-1:0]       acc_t;

  typedef struct packed {
    msums_t w;
    msums_t gs;
    msums_t gt;
  } sums_t;

  typedef struct packed {
    logic signed [ResW-1:0] weight;
    logic signed [ResW-1:0] grad_s;
    logic signed [ResW-1:0] grad_t;
    logic                   sat;
  } result_t;

  function automatic pow_t mono(pow_t a, pow_t b);
    logic [2*PowW-1:0] p;
    p = a * b;
    return p[PowW+MonoShift-1:MonoShift];
  endfunction

  function automatic msum_t scale(int unsigned k, pow_t v);
    return MonoW'(k) * MonoW'(v);
  endfunction

  // x[i][j] = mono(a^i, b^j), a being the variable of differentiation
  function automatic msums_t grad_sums(pows_t a, cross_t x);
    msums_t g;
    g     = '0;
    g[1]  = scale(2, a[1]);
    g[2]  = scale(3, a[2]);
    g[3]  = scale(4, a[3]);
    g[4]  = scale(2, x[1][2]);
    g[5]  = scale(5, a[4]);
    g[6]  = scale(2, x[1][3]) + scale(3, x[2][2]);
    g[7]  = scale(6, a[5]);
    g[8]  = scale(2, x[1][4]) + scale(4, x[3][2]);
    g[9]  = scale(3, x[2][3]);
    g[10] = scale(7, a[6]);
    g[11] = scale(2, x[1][5]) + scale(5, x[4][2]);
    g[12] = scale(3, x[2][4]) + scale(4, x[3][3]);
    return g;
  endfunction

  function automatic msums_t weight_sums(pows_t s, pows_t t, cross_t x);
    msums_t w;
    w[0]  = MonoW'(OneQ16);
    w[1]  = MonoW'(s[2]) + MonoW'(t[2]);
    w[2]  = MonoW'(s[3]) + MonoW'(t[3]);
    w[3]  = MonoW'(s[4]) + MonoW'(t[4]);
    w[4]  = MonoW'(x[2][2]);
    w[5]  = MonoW'(s[5]) + MonoW'(t[5]);
    w[6]  = MonoW'(x[2][3]) + MonoW'(x[3][2]);
    w[7]  = MonoW'(s[6]) + MonoW'(t[6]);
    w[8]  = MonoW'(x[2][4]) + MonoW'(x[4][2]);
    w[9]  = MonoW'(x[3][3]);
    w[10] = MonoW'(s[7]) + MonoW'(t[7]);
    w[11] = MonoW'(x[2][5]) + MonoW'(x[5][2]);
    w[12] = MonoW'(x[3][4]) + MonoW'(x[4][3]);
    return w;
  endfunction

endpackage

// ----- rtl/ssw_if.sv -----
// Request and response channel interfaces of the symmetric septic weight block.
interface ssw_req_if;
  import ssw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] s_coord;
  logic [CoordW-1:0] t_coord;
  modport source (output valid, s_coord, t_coord, input ready);
  modport sink (input valid, s_coord, t_coord, output ready);
  modport monitor (input valid, ready, s_coord, t_coord);
endinterface

interface ssw_rsp_if;
  import ssw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [ResW-1:0] weight_value;
  logic signed [ResW-1:0] grad_s_value;
  logic signed [ResW-1:0] grad_t_value;
  logic                   saturated_flag;
  modport source (output valid, weight_value, grad_s_value, grad_t_value, saturated_flag,
                  input ready);
  modport sink (input valid, weight_value, grad_s_value, grad_t_value, saturated_flag,
                output ready);
  modport monitor (input valid, ready, weight_value, grad_s_value, grad_t_value,
                   saturated_flag);
endinterface

// ----- rtl/ssw_pow.sv -----
// Power stages: capture coordinates, then powers two through seven of s and t.
module ssw_pow
  import ssw_pkg::*;
(
  input  logic                 clk_i,
  input  logic [PowStages-1:0] en_i,
  input  logic [CoordW-1:0]    s_coord_i,
  input  logic [CoordW-1:0]    t_coord_i,
  output pows_t [1:0]          pows_o
);

  logic [1:0][CoordW-1:0] x0_q;
  pows_t [1:0] p1_d, p1_q, p2_d, p2_q, p3_d, p3_q;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      p1_d[a]    = '0;
      p1_d[a][0] = OneQ16;
      p1_d[a][1] = PowW'(x0_q[a]);
      p1_d[a][2] = mono(PowW'(x0_q[a]), PowW'(x0_q[a]));
      p2_d[a]    = p1_q[a];
      p2_d[a][3] = mono(p1_q[a][2], p1_q[a][1]);
      p2_d[a][4] = mono(p1_q[a][2], p1_q[a][2]);
      p3_d[a]    = p2_q[a];
      p3_d[a][5] = mono(p2_q[a][2], p2_q[a][3]);
      p3_d[a][6] = mono(p2_q[a][3], p2_q[a][3]);
      p3_d[a][7] = mono(p2_q[a][4], p2_q[a][3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x0_q[0] <= s_coord_i;
      x0_q[1] <= t_coord_i;
    end
    if (en_i[1]) p1_q <= p1_d;
    if (en_i[2]) p2_q <= p2_d;
    if (en_i[3]) p3_q <= p3_d;
  end

  assign pows_o = p3_q;

endmodule

// ----- rtl/ssw_mono.sv -----
// Monomial stages: mixed products of s and t powers, then the per-coefficient monomial sums.
module ssw_mono
  import ssw_pkg::*;
(
  input  logic                 clk_i,
  input  logic [MonStages-1:0] en_i,
  input  pows_t [1:0]          pows_i,
  output sums_t                sums_o
);

  cross_t      x_d, x_q, xt;
  pows_t [1:0] p4_q;
  sums_t       sums_d, sums_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        if (i >= 1 && j >= 1 && i <= 5 && j <= 5 && i + j >= 3 && i + j <= 7) begin
          x_d[i][j] = mono(pows_i[0][i], pows_i[1][j]);
        end else begin
          x_d[i][j] = '0;
        end
        xt[j][i] = x_q[i][j];
      end
    end
    sums_d.w  = weight_sums(p4_q[0], p4_q[1], x_q);
    sums_d.gs = grad_sums(p4_q[0], x_q);
    sums_d.gt = grad_sums(p4_q[1], xt);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q  <= x_d;
      p4_q <= pows_i;
    end
    if (en_i[1]) sums_q <= sums_d;
  end

  assign sums_o = sums_q;

endmodule

// ----- rtl/ssw_accum.sv -----
// Accumulate stages: coefficient products, two-level sum, floor to Q16.16 and saturate.
module ssw_accum
  import ssw_pkg::*;
(
  input  logic                 clk_i,
  input  logic [AccStages-1:0] en_i,
  input  coefs_t               coefs_i,
  input  sums_t                sums_i,
  output result_t              res_o
);

  localparam acc_t SatMax = acc_t'(64'sd2147483647);
  localparam acc_t SatMin = acc_t'(-64'sd2147483648);

  prods_t [2:0]                  prod_d, prod_q;
  acc_t [2:0][NumGroups-1:0]     part_d, part_q;
  acc_t [2:0]                    tot_d, tot_q;
  msums_t [2:0]                  m;
  result_t                       res_d, res_q;
  logic [2:0]                    clip;
  logic signed [2:0][ResW-1:0]   val;

  always_comb begin
    m[0] = sums_i.w;
    m[1] = sums_i.gs;
    m[2] = sums_i.gt;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < NumCoef; j++) begin
        prod_d[k][j] = $signed({{(ProdW-CoefW){coefs_i[j][CoefW-1]}}, coefs_i[j]})
                     * $signed({{(ProdW-MonoW){1'b0}}, m[k][j]});
      end
      for (int g = 0; g < NumGroups; g++) begin
        part_d[k][g] = '0;
        for (int j = 4*g; j < 4*g + 4; j++) begin
          if (j < NumCoef) part_d[k][g] = part_d[k][g] + acc_t'(prod_q[k][j]);
        end
      end
      tot_d[k] = part_q[k][0] + part_q[k][1] + part_q[k][2] + part_q[k][3];
    end
    for (int k = 0; k < 3; k++) begin
      acc_t q;
      q = tot_q[k] >>> FracDrop;
      clip[k] = 1'b0;
      if (q > SatMax) begin
        val[k]  = ResW'(SatMax);
        clip[k] = 1'b1;
      end else if (q < SatMin) begin
        val[k]  = ResW'(SatMin);
        clip[k] = 1'b1;
      end else begin
        val[k] = q[ResW-1:0];
      end
    end
    res_d.weight = val[0];
    res_d.grad_s = val[1];
    res_d.grad_t = val[2];
    res_d.sat    = |clip;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) prod_q <= prod_d;
    if (en_i[1]) part_q <= part_d;
    if (en_i[2]) tot_q  <= tot_d;
    if (en_i[3]) res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- rtl/septic_symmetric_weight_with_gradient.sv -----
// Top level of the symmetric septic weight and gradient pipeline with its register port.
//
//  channel   dir  handshake              payload
//  req_i     in   valid/ready            s_coord, t_coord (Q1.16)
//  rsp_o     out  valid/ready            weight/grad_s/grad_t (Q16.16), saturated_flag
//  apb       in   psel/penable/pwrite    paddr[4:3] selects coeff_group_0..3, 64-bit data
//
//  One request per cycle, while rsp_o is not stalled, through 10 register stages.
//  4 power stages, 2 monomial stages, 4 product/sum/saturate stages.
//  A stage advances when empty or when the stage after it advances, so bubbles
//  fill under a stalled rsp_o and a stall drops or repeats nothing.
//  rst_ni clears the stage valid bits and the coefficient registers.
module septic_symmetric_weight_with_gradient
  import ssw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  ssw_req_if.sink             req_i,
  ssw_rsp_if.source           rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [NumGroups-1:0][CfgDataW-1:0] grp_q;
  logic [NumStages-1:0]               v_q;
  logic [NumStages:0]                 en;
  coefs_t                             coefs;
  pows_t [1:0]                        pows;
  sums_t                              sums;
  result_t                            res;
  reg_idx_e                           idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegCoef0: grp_q[0] <= pwdata;
        RegCoef1: grp_q[1] <= pwdata;
        RegCoef2: grp_q[2] <= pwdata;
        RegCoef3: grp_q[3] <= {{(CfgDataW-CfgRegW){1'b0}}, pwdata[CfgRegW-1:0]};
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegCoef0: prdata = grp_q[0];
      RegCoef1: prdata = grp_q[1];
      RegCoef2: prdata = grp_q[2];
      RegCoef3: prdata = grp_q[3];
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    for (int j = 0; j < NumCoef; j++) begin
      coefs[j] = grp_q[j/4][16*(j%4) +: CoefW];
    end
  end

  always_comb begin
    en[NumStages] = rsp_o.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= req_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign req_i.ready = en[0];

  ssw_pow u_pow (
    .clk_i     (clk_i),
    .en_i      (en[PowStages-1:0]),
    .s_coord_i (req_i.s_coord),
    .t_coord_i (req_i.t_coord),
    .pows_o    (pows)
  );

  ssw_mono u_mono (
    .clk_i  (clk_i),
    .en_i   (en[PowStages+MonStages-1:PowStages]),
    .pows_i (pows),
    .sums_o (sums)
  );

  ssw_accum u_accum (
    .clk_i   (clk_i),
    .en_i    (en[NumStages-1:PowStages+MonStages]),
    .coefs_i (coefs),
    .sums_i  (sums),
    .res_o   (res)
  );

  assign rsp_o.valid          = v_q[NumStages-1];
  assign rsp_o.weight_value   = res.weight;
  assign rsp_o.grad_s_value   = res.grad_s;
  assign rsp_o.grad_t_value   = res.grad_t;
  assign rsp_o.saturated_flag = res.sat;

endmodule

// ----- rtl/ssw_checker.sv -----
// Port-level checker for the symmetric septic weight block and its bind.
module ssw_checker
  import ssw_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input logic signed [ResW-1:0] weight_i,
  input logic signed [ResW-1:0] grad_s_i,
  input logic signed [ResW-1:0] grad_t_i,
  input logic                   sat_i
);

  localparam logic signed [ResW-1:0] Max32 = {1'b0, {(ResW-1){1'b1}}};
  localparam logic signed [ResW-1:0] Min32 = {1'b1, {(ResW-1){1'b0}}};

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(weight_i)
      && $stable(grad_s_i) && $stable(grad_t_i) && $stable(sat_i))
    else $error("response changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i || rsp_ready_i |-> req_ready_i)
    else $error("request stalled while output stage drains");

  a_flag_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && weight_i != Max32 && weight_i != Min32
      && grad_s_i != Max32 && grad_s_i != Min32
      && grad_t_i != Max32 && grad_t_i != Min32
      |-> !sat_i)
    else $error("saturation flag without a clipped result");

endmodule

bind septic_symmetric_weight_with_gradient ssw_checker u_ssw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .weight_i    (rsp_o.weight_value),
  .grad_s_i    (rsp_o.grad_s_value),
  .grad_t_i    (rsp_o.grad_t_value),
  .sat_i       (rsp_o.saturated_flag)
);

// ----- dv/tb_septic_symmetric_weight_with_gradient.sv -----
// Self-checking testbench for the symmetric septic weight and gradient pipeline.
module tb_septic_symmetric_weight_with_gradient;
  import ssw_pkg::*;

  typedef struct {
    logic [CoordW-1:0] s;
    logic [CoordW-1:0] t;
  } coord_pair_t;

  typedef struct {
    logic [ResW-1:0] weight;
    logic [ResW-1:0] grad_s;
    logic [ResW-1:0] grad_t;
    logic            sat;
  } weight_res_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  ssw_req_if req_if ();
  ssw_rsp_if rsp_if ();

  septic_symmetric_weight_with_gradient i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if.sink),
    .rsp_o   (rsp_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [63:0]   coef_grp [NumGroups];
  coord_pair_t   pending_reqs [$];
  weight_res_t   expected_res [$];
  int            mismatches;
  int            burst_left;
  int            gap_left;
  int            stall_mode;
  int            stall_cnt;
  logic          req_taken;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("tb_septic_symmetric_weight_with_gradient: done, errors");
    $finish;
  end

  function automatic longint coef_of(int i);
    logic [15:0] raw;
    raw = coef_grp[i / 4][16 * (i % 4) +: 16];
    return longint'($signed(raw));
  endfunction

  function automatic longint unsigned mul16(longint unsigned a, longint unsigned b);
    return (a * b) >> 16;
  endfunction

  function automatic logic [ResW-1:0] to_q16(longint v, ref logic sat);
    longint q;
    q = v >>> 12;
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
      sat = 1'b1;
    end
    if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
      sat = 1'b1;
    end
    return q[ResW-1:0];
  endfunction

  function automatic longint slope(longint unsigned a[8], longint unsigned b[8]);
    longint unsigned m[13];
    longint r;
    m[0]  = 0;
    m[1]  = 2 * a[1];
    m[2]  = 3 * a[2];
    m[3]  = 4 * a[3];
    m[4]  = 2 * mul16(a[1], b[2]);
    m[5]  = 5 * a[4];
    m[6]  = 2 * mul16(a[1], b[3]) + 3 * mul16(a[2], b[2]);
    m[7]  = 6 * a[5];
    m[8]  = 2 * mul16(a[1], b[4]) + 4 * mul16(a[3], b[2]);
    m[9]  = 3 * mul16(a[2], b[3]);
    m[10] = 7 * a[6];
    m[11] = 2 * mul16(a[1], b[5]) + 5 * mul16(a[4], b[2]);
    m[12] = 3 * mul16(a[2], b[4]) + 4 * mul16(a[3], b[3]);
    r = 0;
    for (int i = 1; i < 13; i++) r += coef_of(i) * longint'(m[i]);
    return r;
  endfunction

  function automatic weight_res_t predict_weight(coord_pair_t c);
    longint unsigned sp[8];
    longint unsigned tp[8];
    longint unsigned m[13];
    longint w;
    weight_res_t r;
    logic sat;
    sp[0] = 65536;
    tp[0] = 65536;
    sp[1] = c.s;
    tp[1] = c.t;
    sp[2] = mul16(sp[1], sp[1]);
    tp[2] = mul16(tp[1], tp[1]);
    sp[3] = mul16(sp[2], sp[1]);
    tp[3] = mul16(tp[2], tp[1]);
    sp[4] = mul16(sp[2], sp[2]);
    tp[4] = mul16(tp[2], tp[2]);
    sp[5] = mul16(sp[2], sp[3]);
    tp[5] = mul16(tp[2], tp[3]);
    sp[6] = mul16(sp[3], sp[3]);
    tp[6] = mul16(tp[3], tp[3]);
    sp[7] = mul16(sp[4], sp[3]);
    tp[7] = mul16(tp[4], tp[3]);
    m[0]  = 65536;
    m[1]  = sp[2] + tp[2];
    m[2]  = sp[3] + tp[3];
    m[3]  = sp[4] + tp[4];
    m[4]  = mul16(sp[2], tp[2]);
    m[5]  = sp[5] + tp[5];
    m[6]  = mul16(sp[2], tp[3]) + mul16(sp[3], tp[2]);
    m[7]  = sp[6] + tp[6];
    m[8]  = mul16(sp[2], tp[4]) + mul16(sp[4], tp[2]);
    m[9]  = mul16(sp[3], tp[3]);
    m[10] = sp[7] + tp[7];
    m[11] = mul16(sp[2], tp[5]) + mul16(sp[5], tp[2]);
    m[12] = mul16(sp[3], tp[4]) + mul16(sp[4], tp[3]);
    w = 0;
    for (int i = 0; i < 13; i++) w += coef_of(i) * longint'(m[i]);
    sat = 1'b0;
    r.weight = to_q16(w, sat);
    r.grad_s = to_q16(slope(sp, tp), sat);
    r.grad_t = to_q16(slope(tp, sp), sat);
    r.sat    = sat;
    return r;
  endfunction

  task automatic write_coef(reg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= CfgAddrW'(8 * int'(idx));
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    coef_grp[idx] = (idx == RegCoef3) ? {48'd0, val[15:0]} : val;
  endtask

  task automatic load_coefs(logic [63:0] g0, logic [63:0] g1, logic [63:0] g2,
                            logic [63:0] g3);
    write_coef(RegCoef0, g0);
    write_coef(RegCoef1, g1);
    write_coef(RegCoef2, g2);
    write_coef(RegCoef3, g3);
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return CoordW'($urandom_range(65537, 131071));
    if (k == 1) return CoordW'(65536);
    if (k == 2) return CoordW'($urandom_range(0, 15));
    return CoordW'($urandom_range(0, 65536));
  endfunction

  function automatic logic [63:0] rand_group();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_req(logic [CoordW-1:0] s, logic [CoordW-1:0] t);
    coord_pair_t c;
    c.s = s;
    c.t = t;
    pending_reqs.push_back(c);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_res.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // driver: bursts of requests separated by random gaps
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.s_coord <= '0;
      req_if.t_coord <= '0;
      burst_left     <= 0;
      gap_left       <= 0;
    end else if (!req_if.valid || req_taken) begin
      if (req_taken) void'(pending_reqs.pop_front());
      if (pending_reqs.size() != 0 && gap_left == 0) begin
        req_if.valid   <= 1'b1;
        req_if.s_coord <= pending_reqs[0].s;
        req_if.t_coord <= pending_reqs[0].t;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_if.valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end
    end
  end

  // predictor: compute expectation on each accepted request
  always @(posedge clk_i) begin
    coord_pair_t c;
    req_taken <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni && req_if.valid && req_if.ready) begin
      c.s = req_if.s_coord;
      c.t = req_if.t_coord;
      expected_res.push_back(predict_weight(c));
    end
  end

  // receiver stall pattern
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_mode   <= 0;
      stall_cnt    <= 0;
    end else begin
      if (stall_cnt == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_cnt  <= $urandom_range(5, 60);
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: compare each accepted response with the oldest expectation
  always @(posedge clk_i) begin
    weight_res_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response w=%h", rsp_if.weight_value);
      end else begin
        e = expected_res.pop_front();
        if (rsp_if.weight_value !== e.weight || rsp_if.grad_s_value !== e.grad_s ||
            rsp_if.grad_t_value !== e.grad_t || rsp_if.saturated_flag !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp w=%h gs=%h gt=%h sat=%b got w=%h gs=%h gt=%h sat=%b",
                     e.weight, e.grad_s, e.grad_t, e.sat, rsp_if.weight_value,
                     rsp_if.grad_s_value, rsp_if.grad_t_value, rsp_if.saturated_flag);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    for (int i = 0; i < NumGroups; i++) coef_grp[i] = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset coefficients are zero
    push_req(CoordW'(65536), CoordW'(0));
    drain();

    load_coefs(64'h1000_F000_0800_1000, 64'hF800_0400_FC00_0200,
               64'h0100_FF00_0080_FF80, 64'h0000_0000_0000_0040);
    push_req(0, 0);
    push_req(CoordW'(65536), CoordW'(65536));
    push_req(CoordW'(65536), 0);
    push_req(0, CoordW'(65536));
    push_req(CoordW'(131071), CoordW'(131071));
    push_req(CoordW'(131071), 0);
    push_req(1, 1);
    push_req(CoordW'(32768), CoordW'(16384));
    push_req(CoordW'(65535), CoordW'(1));
    push_req(CoordW'(86000), CoordW'(43690));
    drain();

    // extremes: saturate positive and negative
    load_coefs({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 64'h7FFF);
    push_req(CoordW'(131071), CoordW'(131071));
    push_req(CoordW'(65536), CoordW'(65536));
    push_req(0, 0);
    push_req(CoordW'(100000), CoordW'(5));
    drain();
    load_coefs({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 64'hFFFF_FFFF_FFFF_8000);
    push_req(CoordW'(131071), CoordW'(131071));
    push_req(CoordW'(65536), CoordW'(65536));
    push_req(0, 0);
    push_req(CoordW'(131071), CoordW'(65536));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      load_coefs(rand_group(), rand_group(), rand_group(), rand_group());
      for (int n = 0; n < 143; n++) push_req(rand_coord(), rand_coord());
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_septic_symmetric_weight_with_gradient: done, clean");
    end else begin
      $display("tb_septic_symmetric_weight_with_gradient: done, errors");
    end
    $finish;
  end

endmodule
